FILE: rtl/core/sgf_pkg.sv
package sgf_pkg;

  // Sizes fixed by the item formats.
  localparam int MAX_SPAN_DEF    = 16;
  localparam int SAMPLE_BITS     = 24;
  localparam int COEFF_BITS      = 24;
  localparam int COEFF_FRAC_BITS = 20;
  localparam int TAP_W           = 6;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 5;

  // Item commands.
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_SPAN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SPAN = 2'd1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEFF_BITS-1:0]  coeff_t;

  typedef struct packed {
    logic              command;
    logic [TAP_W-1:0]  tap_index;
    coeff_t            coeff_value;
    sample_t           sample;
    logic              last_sample;
  } in_item_t;

  typedef struct packed {
    sample_t smoothed;
    logic    last_result;
    logic    saturated;
  } out_item_t;

  // Controls broadcast to every cell of the window chain.
  typedef struct packed {
    logic push;
    logic fill;
    logic snap;
    logic shift;
  } cell_ctl_t;

endpackage

FILE: rtl/core/sgf_cell.sv
module sgf_cell (
  input  logic               clk,
  input  logic               rst,
  input  sgf_pkg::cell_ctl_t ctl,
  input  logic               coef_we,
  input  sgf_pkg::coeff_t    coef_data,
  input  sgf_pkg::sample_t   fill_x,
  input  sgf_pkg::sample_t   win_prev,
  input  sgf_pkg::sample_t   ws_prev,
  input  sgf_pkg::coeff_t    cw_next,
  output sgf_pkg::sample_t   win,
  output sgf_pkg::sample_t   ws,
  output sgf_pkg::coeff_t    cw
);
  import sgf_pkg::*;

  coeff_t coef;

  // Coefficient slot of this cell; cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (coef_we) begin
      coef <= coef_data;
    end
  end

  // Window sample: shifts in from the younger neighbor, or takes the
  // first sample of a record in every cell at once.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      win <= ctl.fill ? fill_x : win_prev;
    end
  end

  // Working copies: samples move toward the older end and coefficients
  // toward the head, so the head multiplier sees matching pairs.
  always_ff @(posedge clk) begin
    if (ctl.snap) begin
      ws <= win;
      cw <= coef;
    end else if (ctl.shift) begin
      ws <= ws_prev;
      cw <= cw_next;
    end
  end

endmodule

FILE: rtl/core/savitzky_golay_fir_smoother_core.sv
// Streaming Savitzky-Golay FIR smoother with loaded coefficients.
// Input channel (in_valid/in_ready/in_item): a transfer with command LOAD
// stores coeff_value in slot tap_index while no record is open; a
// transfer with command SAMPLE pushes one sample of a record, and
// last_sample closes the record. Output channel (out_valid/out_ready/
// out_item) gives one smoothed value per sample, lagging the input by
// right_span samples; the last sample flushes the rest of the record.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) sets
// left_span and right_span (clamped to MAX_SPAN), only between records;
// cfg_ready is high only while the block is idle.
// Each result is summed by one shared multiplier at the head of the cell
// chain, one tap a cycle: out_valid rises after S_SNAP, S_MAC over every
// tap, S_DRAIN and S_RND, and in_ready returns via S_ADV after the last
// result of an item is transferred. A coefficient load keeps the block
// idle. A record end with right_span pending results costs that many
// extra result times. When the receiver stalls, the result is held in
// the output register and no input is taken. Reset clears coefficients,
// spans to 2, and closes any record; no clearing pass is needed.
module savitzky_golay_fir_smoother_core #(
  parameter int MAX_SPAN = sgf_pkg::MAX_SPAN_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  sgf_pkg::in_item_t                   in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sgf_pkg::out_item_t                  out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sgf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sgf_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import sgf_pkg::*;

  localparam int DEPTH  = 2 * MAX_SPAN + 1;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int SEEN_W = $clog2(MAX_SPAN + 1);
  localparam int PROD_W = SAMPLE_BITS + COEFF_BITS;
  localparam int ACC_W  = PROD_W + IDX_W + 1;

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (COEFF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] HI =
    {{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] LO =
    {{(ACC_W - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_NEXT  = 3'd1;
  localparam logic [2:0] S_SNAP  = 3'd2;
  localparam logic [2:0] S_MAC   = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_RND   = 3'd5;
  localparam logic [2:0] S_WAIT  = 3'd6;
  localparam logic [2:0] S_ADV   = 3'd7;

  logic [2:0]        state;
  logic [SEEN_W-1:0] left_span;
  logic [SEEN_W-1:0] right_span;
  logic [SEEN_W-1:0] samples_seen;
  logic              in_record;
  logic [SEEN_W-1:0] skip;
  logic [SEEN_W-1:0] pads_left;
  logic              last_rec;
  logic [IDX_W-1:0]  k;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  sample_t    win_arr [DEPTH];
  sample_t    ws_arr  [DEPTH];
  coeff_t     cw_arr  [DEPTH];
  logic       coef_we [DEPTH];
  cell_ctl_t  ctl;
  sample_t    head_in;
  logic       in_fire;
  logic       smp_fire;
  logic [IDX_W-1:0] m_idx;
  logic signed [ACC_W-1:0] q;
  logic signed [ACC_W-1:0] y;
  logic [CFG_DATA_W:0]     cfg_wide;
  logic [SEEN_W-1:0]       cfg_span;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign smp_fire  = in_fire & (in_item.command == CMD_SAMPLE);
  assign m_idx     = IDX_W'({1'b0, left_span} + {1'b0, right_span});

  // Chain controls: real pushes at transfer, pad pushes while flushing.
  always_comb begin
    ctl.push  = smp_fire || (state == S_ADV && pads_left != '0);
    ctl.fill  = smp_fire && !in_record;
    ctl.snap  = (state == S_SNAP);
    ctl.shift = (state == S_MAC);
    head_in   = (state == S_IDLE) ? in_item.sample : win_arr[0];
  end

  // The cell chain.
  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    sample_t win_prev;
    sample_t ws_prev;
    coeff_t  cw_next;
    if (j == 0) begin : g_head
      assign win_prev = head_in;
      assign ws_prev  = '0;
    end else begin : g_body
      assign win_prev = win_arr[j-1];
      assign ws_prev  = ws_arr[j-1];
    end
    if (j == DEPTH - 1) begin : g_tail
      assign cw_next = '0;
    end else begin : g_link
      assign cw_next = cw_arr[j+1];
    end
    assign coef_we[j] = in_fire && in_item.command == CMD_LOAD && !in_record &&
                        int'(in_item.tap_index) == j;
    sgf_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .coef_we   (coef_we[j]),
      .coef_data (in_item.coeff_value),
      .fill_x    (in_item.sample),
      .win_prev  (win_prev),
      .ws_prev   (ws_prev),
      .cw_next   (cw_next),
      .win       (win_arr[j]),
      .ws        (ws_arr[j]),
      .cw        (cw_arr[j])
    );
  end

  // Span registers, clamped, written only between records.
  assign cfg_wide = {1'b0, cfg_data};
  assign cfg_span = (int'(cfg_wide) > MAX_SPAN) ? SEEN_W'(MAX_SPAN)
                                                : SEEN_W'(cfg_wide);
  always_ff @(posedge clk) begin
    if (rst) begin
      left_span  <= SEEN_W'(2);
      right_span <= SEEN_W'(2);
    end else if (cfg_valid && cfg_ready && !in_record) begin
      unique case (cfg_index)
        REG_LEFT_SPAN:  left_span  <= cfg_span;
        REG_RIGHT_SPAN: right_span <= cfg_span;
        default: ;
      endcase
    end
  end

  // Rounding to nearest with ties upward, then saturation.
  assign q = acc + HALF;
  assign y = q >>> COEFF_FRAC_BITS;

  // Sequencer: record bookkeeping, flush padding and the head MAC.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      in_record    <= 1'b0;
      samples_seen <= '0;
      skip         <= '0;
      pads_left    <= '0;
      last_rec     <= 1'b0;
      k            <= '0;
      out_valid    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (smp_fire) begin
            skip      <= (samples_seen >= right_span) ? '0 : right_span - samples_seen;
            pads_left <= in_item.last_sample ? right_span : '0;
            last_rec  <= in_item.last_sample;
            if (in_item.last_sample) begin
              in_record    <= 1'b0;
              samples_seen <= '0;
            end else begin
              in_record <= 1'b1;
              if (!in_record) begin
                samples_seen <= SEEN_W'(1);
              end else if (int'(samples_seen) < MAX_SPAN) begin
                samples_seen <= samples_seen + 1'b1;
              end
            end
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (skip == '0) begin
            state <= S_SNAP;
          end else begin
            skip  <= skip - 1'b1;
            state <= S_ADV;
          end
        end
        S_SNAP: begin
          k     <= '0;
          state <= S_MAC;
        end
        S_MAC: begin
          k <= k + 1'b1;
          if (k == m_idx) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: state <= S_RND;
        S_RND: begin
          out_valid <= 1'b1;
          state     <= S_WAIT;
        end
        S_WAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_ADV;
          end
        end
        S_ADV: begin
          if (pads_left != '0) begin
            pads_left <= pads_left - 1'b1;
            state     <= S_NEXT;
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Multiply-accumulate datapath and output register.
  always_ff @(posedge clk) begin
    if (state == S_SNAP) begin
      prod <= '0;
      acc  <= '0;
    end else if (state == S_MAC) begin
      prod <= cw_arr[0] * ws_arr[m_idx];
      acc  <= acc + ACC_W'(prod);
    end else if (state == S_DRAIN) begin
      acc <= acc + ACC_W'(prod);
    end
    if (state == S_RND) begin
      out_item.last_result <= last_rec && (pads_left == '0);
      if (y > HI) begin
        out_item.smoothed  <= HI[SAMPLE_BITS-1:0];
        out_item.saturated <= 1'b1;
      end else if (y < LO) begin
        out_item.smoothed  <= LO[SAMPLE_BITS-1:0];
        out_item.saturated <= 1'b1;
      end else begin
        out_item.smoothed  <= y[SAMPLE_BITS-1:0];
        out_item.saturated <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/sgf_checker.sv
module sgf_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input sgf_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_ready,
  input sgf_pkg::out_item_t out_item
);
  import sgf_pkg::*;

  localparam sample_t S_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam sample_t S_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // A sample transfer starts work, so input closes the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_item.command == CMD_SAMPLE |=> !in_ready)
    else $error("input open right after a sample");

  // One item at a time: no input while a result waits.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input open while a result waits");

  // A clipped result sits at a rail.
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.saturated |->
      out_item.smoothed == S_MAX || out_item.smoothed == S_MIN)
    else $error("saturated result off the rails");

endmodule

bind savitzky_golay_fir_smoother_core sgf_checker u_sgf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
